// File: design/htt_pkg.sv
package htt_pkg;

  // Offset limit: a byte at or beyond this offset overflows
  localparam int MAX_HEADER_BYTES = 65535;
  localparam int POS_LIMIT = (MAX_HEADER_BYTES < 65535) ? MAX_HEADER_BYTES : 65535;

  localparam int NUM_METHODS = 7;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_REQLINE = 3'd1;
  localparam logic [2:0] EV_HEADER  = 3'd2;
  localparam logic [2:0] EV_END     = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  localparam logic ERR_NO_SPACES = 1'b0;
  localparam logic ERR_OVERFLOW  = 1'b1;

  typedef enum logic [1:0] {
    PH_REQ,
    PH_HDR,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_request;
  } req_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  event_kind;
    logic [2:0]  method_code;
    logic [15:0] first_offset;
    logic [15:0] first_length;
    logic [15:0] second_offset;
    logic [15:0] second_length;
    logic        query_present;
    logic [15:0] header_bytes;
    logic        error_code;
  } res_t;

  // A position that may be absent
  typedef struct packed {
    logic        found;
    logic [15:0] at;
  } opt_pos_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] pos;
    logic        pending_cr;
    logic        after_term;
    logic [15:0] line_begin;
    opt_pos_t    space_one;
    opt_pos_t    space_two;
    opt_pos_t    question;
    opt_pos_t    colon;
    opt_pos_t    value_begin;
    logic [NUM_METHODS-1:0] method_mask;
  } parse_st_t;

  function automatic logic [15:0] meth_len(input logic [2:0] k);
    logic [15:0] len;
    case (k)
      3'd0:    len = 16'd3;
      3'd1:    len = 16'd4;
      3'd2:    len = 16'd3;
      3'd3:    len = 16'd6;
      3'd4:    len = 16'd5;
      3'd5:    len = 16'd4;
      3'd6:    len = 16'd7;
      default: len = 16'd0;
    endcase
    return len;
  endfunction

  // Character i of method name k, names padded to seven characters
  function automatic logic [7:0] meth_char(input logic [2:0] k, input logic [2:0] i);
    logic [55:0] name;
    logic [2:0]  sel;
    case (k)
      3'd0:    name = "GET    ";
      3'd1:    name = "POST   ";
      3'd2:    name = "PUT    ";
      3'd3:    name = "DELETE ";
      3'd4:    name = "PATCH  ";
      3'd5:    name = "HEAD   ";
      3'd6:    name = "OPTIONS";
      default: name = "       ";
    endcase
    sel = 3'd6 - i;
    return name[8*sel +: 8];
  endfunction

  // Start a new line at the given offset
  function automatic parse_st_t new_line(input parse_st_t s, input logic [15:0] start);
    parse_st_t n;
    n = s;
    n.line_begin  = start;
    n.space_one   = '0;
    n.space_two   = '0;
    n.question    = '0;
    n.colon       = '0;
    n.value_begin = '0;
    n.method_mask = '1;
    return n;
  endfunction

  function automatic parse_st_t st_reset();
    parse_st_t n;
    n = '0;
    n.phase = PH_REQ;
    return new_line(n, 16'd0);
  endfunction

  // Track one data character at offset q
  function automatic parse_st_t feed(input parse_st_t s, input logic [7:0] c,
                                     input logic [15:0] q);
    parse_st_t   n;
    logic [15:0] idx;
    logic [7:0]  up;
    n = s;
    n.after_term = 1'b0;
    idx = q - s.line_begin;
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (s.phase == PH_REQ) begin
      if (!s.space_one.found) begin
        if (c == CH_SPACE) begin
          n.space_one = '{found: 1'b1, at: q};
        end else begin
          for (int k = 0; k < NUM_METHODS; k++) begin
            if (idx >= meth_len(3'(k)) || meth_char(3'(k), idx[2:0]) != up) begin
              n.method_mask[k] = 1'b0;
            end
          end
        end
      end else if (!s.space_two.found) begin
        if (c == CH_SPACE) begin
          n.space_two = '{found: 1'b1, at: q};
        end else if (c == CH_QMARK && !s.question.found) begin
          n.question = '{found: 1'b1, at: q};
        end
      end
    end else if (s.phase == PH_HDR) begin
      if (!s.colon.found) begin
        if (c == CH_COLON) begin
          n.colon = '{found: 1'b1, at: q};
        end
      end else if (!s.value_begin.found && c != CH_SPACE) begin
        n.value_begin = '{found: 1'b1, at: q};
      end
    end
    return n;
  endfunction

endpackage

// File: design/htt_core.sv
module htt_core import htt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t item,
  output res_t res
);

  parse_st_t st;
  parse_st_t st_next;

  // Hold parser state, advance once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset();
    end else if (step) begin
      st <= st_next;
    end
  end

  // Work out the result and next state for one byte
  always_comb begin
    parse_st_t   s;
    parse_st_t   t;
    logic [7:0]  b;
    logic [15:0] cr;
    logic [15:0] pstart;
    logic [15:0] mlen;
    logic        hit;
    b = item.data_byte;
    s = item.start_of_request ? st_reset() : st;
    t = s;
    cr = s.pos - 16'd1;
    pstart = s.space_one.at + 16'd1;
    mlen = s.space_one.at - s.line_begin;
    hit = 1'b0;
    res = '0;
    res.byte_out = b;
    if (s.phase == PH_DONE || s.phase == PH_ERR) begin
      t = s;
    end else if (int'(s.pos) + 1 > POS_LIMIT) begin
      // Offset overflow
      t.phase = PH_ERR;
      res.event_kind = EV_ERROR;
      res.error_code = ERR_OVERFLOW;
    end else if (s.pending_cr && b == CH_LF) begin
      // Line end: report the finished line
      t.pending_cr = 1'b0;
      if (s.after_term) begin
        res.event_kind = EV_END;
        res.header_bytes = s.pos + 16'd1;
        t.phase = PH_DONE;
      end else if (cr == s.line_begin) begin
        t.phase = PH_HDR;
      end else if (s.phase == PH_REQ) begin
        if (s.space_two.found) begin
          for (int k = 0; k < NUM_METHODS; k++) begin
            if (!hit && s.method_mask[k] && meth_len(3'(k)) == mlen) begin
              hit = 1'b1;
              res.method_code = 3'(k);
            end
          end
          res.event_kind = EV_REQLINE;
          res.first_offset = pstart;
          if (s.question.found) begin
            res.first_length  = s.question.at - pstart;
            res.second_offset = s.question.at + 16'd1;
            res.second_length = s.space_two.at - s.question.at - 16'd1;
            res.query_present = 1'b1;
          end else begin
            res.first_length = s.space_two.at - pstart;
          end
          t.phase = PH_HDR;
        end else begin
          res.event_kind = EV_ERROR;
          res.error_code = ERR_NO_SPACES;
          t.phase = PH_ERR;
        end
      end else if (s.colon.found) begin
        res.event_kind = EV_HEADER;
        res.first_offset = s.line_begin;
        res.first_length = s.colon.at - s.line_begin;
        if (s.value_begin.found) begin
          res.second_offset = s.value_begin.at;
          res.second_length = cr - s.value_begin.at;
        end else begin
          res.second_offset = cr;
        end
      end
      t = new_line(t, s.pos + 16'd1);
      t.after_term = 1'b1;
      t.pos = s.pos + 16'd1;
    end else begin
      // Ordinary byte: flush a held CR as data first
      if (s.pending_cr) begin
        t = feed(t, CH_CR, cr);
        t.pending_cr = 1'b0;
      end
      if (t.phase == PH_HDR && !t.colon.found && b >= "A" && b <= "Z") begin
        res.byte_out = b + 8'd32;
      end
      if (b == CH_CR) begin
        t.pending_cr = 1'b1;
      end else begin
        t = feed(t, b, s.pos);
      end
      t.pos = s.pos + 16'd1;
    end
    st_next = t;
  end

  // Finished or failed requests only echo bytes
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    step && !item.start_of_request && (st.phase == PH_DONE || st.phase == PH_ERR)
    |-> res.event_kind == EV_NONE)
    else $error("event reported after end of headers or error");

  // End of headers closes the request
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    step && res.event_kind == EV_END |=> st.phase == PH_DONE)
    else $error("phase not done after end of headers");

  // Request line events come only from the request line phase
  a_reqline_phase: assert property (@(posedge clk) disable iff (rst)
    step && res.event_kind == EV_REQLINE |-> (item.start_of_request || st.phase == PH_REQ))
    else $error("request line event outside request line phase");

endmodule

// File: design/http_request_header_tokenizer.sv
// Channel  | Valid          | Ready          | Payload
// request  | request_valid  | request_ready  | request (req_t: data_byte, start_of_request)
// result   | result_valid   | result_ready   | result  (res_t: one result per byte)
//
// One byte per cycle sustained while results are taken; an accepted byte passes the
// input register, then parse logic into the result register, where result_valid rises.
// Parser state advances once per byte, in the cycle the byte moves to the result register.
// Synchronous reset clears the parser state and both valid flags.
// A stalled result holds the input register; request_ready drops only when both are full.
module http_request_header_tokenizer import htt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic request_valid,
  output logic request_ready,
  input  req_t request,
  output logic result_valid,
  input  logic result_ready,
  output res_t result
);

  logic s1_valid;
  req_t s1_item;
  logic advance;
  res_t core_res;

  assign advance       = s1_valid && (!result_valid || result_ready);
  assign request_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request_valid && request_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (request_valid && request_ready) begin
      s1_item <= request;
    end
  end

  htt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .res  (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Both stages full and stalled: no new request
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result_valid && !result_ready |-> !request_ready)
    else $error("request taken while both stages are full");

  // A parsed byte always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("parsed byte lost");

endmodule

// File: bench/http_request_header_tokenizer_checker.sv
module http_request_header_tokenizer_checker import htt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic request_valid,
  input  logic request_ready,
  input  req_t request,
  input  logic result_valid,
  input  logic result_ready,
  input  res_t result,
  output int   mismatches,
  output int   outstanding,
  output int   compared
);
  timeunit 1ns;
  timeprecision 1ps;

  // Marks a position that has not been seen on the current line
  localparam int ABSENT = 32'h1_0000;

  res_t  token_forecast[$];
  res_t  want;
  res_t  got;
  string diff;
  int    bad_count = 0;
  int    seen_count = 0;

  // Tokenizer state, one copy kept here
  phase_t                 stage;
  int                     at;
  int                     line_origin;
  int                     sp1;
  int                     sp2;
  int                     qmark;
  int                     colon_at;
  int                     val_at;
  bit                     cr_held;
  bit                     line_just_ended;
  logic [NUM_METHODS-1:0] verb_hits;

  function automatic string verb_text(input int k);
    case (k)
      0:       return "GET";
      1:       return "POST";
      2:       return "PUT";
      3:       return "DELETE";
      4:       return "PATCH";
      5:       return "HEAD";
      default: return "OPTIONS";
    endcase
  endfunction

  task automatic restart_line(input int start);
    line_origin = start;
    sp1         = ABSENT;
    sp2         = ABSENT;
    qmark       = ABSENT;
    colon_at    = ABSENT;
    val_at      = ABSENT;
    verb_hits   = '1;
  endtask

  task automatic reset_model();
    at              = 0;
    stage           = PH_REQ;
    cr_held         = 1'b0;
    line_just_ended = 1'b0;
    restart_line(0);
  endtask

  // Track one data character at offset q
  task automatic track_char(input logic [7:0] c, input int q);
    int         idx;
    logic [7:0] up;
    string      name;
    line_just_ended = 1'b0;
    if (stage == PH_REQ) begin
      if (sp1 == ABSENT) begin
        if (c == CH_SPACE) begin
          sp1 = q;
        end else begin
          // narrow the candidate methods, case-insensitive
          idx = q - line_origin;
          up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
          for (int k = 0; k < NUM_METHODS; k++) begin
            name = verb_text(k);
            if (idx >= name.len() || name[idx] != up) verb_hits[k] = 1'b0;
          end
        end
      end else if (sp2 == ABSENT) begin
        if (c == CH_SPACE) begin
          sp2 = q;
        end else if (c == CH_QMARK && qmark == ABSENT) begin
          qmark = q;
        end
      end
    end else if (stage == PH_HDR) begin
      if (colon_at == ABSENT) begin
        if (c == CH_COLON) colon_at = q;
      end else if (val_at == ABSENT && c != CH_SPACE) begin
        val_at = q;
      end
    end
  endtask

  // Advance the tokenizer by one byte and form the result it yields
  task automatic tokenize_byte(input req_t rq, output res_t tok);
    int         cr_at;
    int         plen;
    int         pstart;
    string      name;
    logic [7:0] b;
    b = rq.data_byte;
    if (rq.start_of_request) reset_model();
    tok = '0;
    tok.byte_out = b;
    if (stage == PH_DONE || stage == PH_ERR) begin
      // echo only, until the next request start
    end else if (at + 1 > POS_LIMIT) begin
      stage = PH_ERR;
      tok.event_kind = EV_ERROR;
      tok.error_code = ERR_OVERFLOW;
    end else if (cr_held && b == CH_LF) begin
      cr_at = at - 1;
      cr_held = 1'b0;
      if (line_just_ended) begin
        // blank line closes the header block
        tok.event_kind = EV_END;
        tok.header_bytes = 16'(at + 1);
        stage = PH_DONE;
      end else if (cr_at == line_origin) begin
        // empty leading line stands in for the request line
        stage = PH_HDR;
      end else if (stage == PH_REQ) begin
        if (sp2 != ABSENT) begin
          plen = sp1 - line_origin;
          for (int k = NUM_METHODS - 1; k >= 0; k--) begin
            name = verb_text(k);
            if (verb_hits[k] && name.len() == plen) tok.method_code = 3'(k);
          end
          pstart = sp1 + 1;
          tok.event_kind = EV_REQLINE;
          tok.first_offset = 16'(pstart);
          if (qmark != ABSENT) begin
            tok.first_length  = 16'(qmark - pstart);
            tok.second_offset = 16'(qmark + 1);
            tok.second_length = 16'(sp2 - qmark - 1);
            tok.query_present = 1'b1;
          end else begin
            tok.first_length = 16'(sp2 - pstart);
          end
          stage = PH_HDR;
        end else begin
          tok.event_kind = EV_ERROR;
          tok.error_code = ERR_NO_SPACES;
          stage = PH_ERR;
        end
      end else if (colon_at != ABSENT) begin
        tok.event_kind   = EV_HEADER;
        tok.first_offset = 16'(line_origin);
        tok.first_length = 16'(colon_at - line_origin);
        if (val_at != ABSENT) begin
          tok.second_offset = 16'(val_at);
          tok.second_length = 16'(cr_at - val_at);
        end else begin
          tok.second_offset = 16'(cr_at);
        end
      end
      restart_line(at + 1);
      line_just_ended = 1'b1;
      at = at + 1;
    end else begin
      // a held CR not followed by LF is plain data
      if (cr_held) begin
        track_char(CH_CR, at - 1);
        cr_held = 1'b0;
      end
      if (stage == PH_HDR && colon_at == ABSENT && b >= "A" && b <= "Z") begin
        tok.byte_out = b + 8'd32;
      end
      if (b == CH_CR) begin
        cr_held = 1'b1;
      end else begin
        track_char(b, at);
      end
      at = at + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      token_forecast.delete();
    end else begin
      // compare each finished result with the oldest prediction
      if (result_valid && result_ready) begin
        got = result;
        if (token_forecast.size() == 0) begin
          bad_count++;
          if (bad_count <= 50) begin
            $display("%0t: result with nothing outstanding: byte %02h event %0d",
                     $time, got.byte_out, got.event_kind);
          end
        end else begin
          want = token_forecast.pop_front();
          seen_count++;
          diff = "";
          if (got.byte_out !== want.byte_out)
            diff = {diff, $sformatf(" byte_out exp %0d got %0d", want.byte_out, got.byte_out)};
          if (got.event_kind !== want.event_kind)
            diff = {diff, $sformatf(" event_kind exp %0d got %0d",
                                    want.event_kind, got.event_kind)};
          if (got.method_code !== want.method_code)
            diff = {diff, $sformatf(" method_code exp %0d got %0d",
                                    want.method_code, got.method_code)};
          if (got.first_offset !== want.first_offset)
            diff = {diff, $sformatf(" first_offset exp %0d got %0d",
                                    want.first_offset, got.first_offset)};
          if (got.first_length !== want.first_length)
            diff = {diff, $sformatf(" first_length exp %0d got %0d",
                                    want.first_length, got.first_length)};
          if (got.second_offset !== want.second_offset)
            diff = {diff, $sformatf(" second_offset exp %0d got %0d",
                                    want.second_offset, got.second_offset)};
          if (got.second_length !== want.second_length)
            diff = {diff, $sformatf(" second_length exp %0d got %0d",
                                    want.second_length, got.second_length)};
          if (got.query_present !== want.query_present)
            diff = {diff, $sformatf(" query_present exp %0d got %0d",
                                    want.query_present, got.query_present)};
          if (got.header_bytes !== want.header_bytes)
            diff = {diff, $sformatf(" header_bytes exp %0d got %0d",
                                    want.header_bytes, got.header_bytes)};
          if (got.error_code !== want.error_code)
            diff = {diff, $sformatf(" error_code exp %0d got %0d",
                                    want.error_code, got.error_code)};
          if (diff != "") begin
            bad_count++;
            if (bad_count <= 50) $display("%0t: result %0d mismatch:%s", $time, seen_count, diff);
          end
        end
      end
      // predict the result of each accepted request
      if (request_valid && request_ready) begin
        tokenize_byte(request, want);
        token_forecast.push_back(want);
      end
    end
    mismatches  <= bad_count;
    outstanding <= token_forecast.size();
    compared    <= seen_count;
  end

endmodule

// File: bench/http_request_header_tokenizer_tb.sv
module http_request_header_tokenizer_tb;
  import htt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        request_valid = 1'b0;
  req_t        request = '0;
  logic        request_ready;
  logic        result_valid;
  logic        result_ready = 1'b0;
  res_t        result;
  int          mismatches;
  int          outstanding;
  int          compared;
  int unsigned cycle_no = 0;
  req_t        byte_stream[$];
  bit          fresh = 1'b0;
  int          request_count = 0;

  // No idling on either side inside this window
  wire calm = (cycle_no >= 250 && cycle_no < 500);

  http_request_header_tokenizer u_top (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  http_request_header_tokenizer_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .compared      (compared)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  function automatic string method_word(input int k);
    case (k)
      0:       return "GET";
      1:       return "POST";
      2:       return "PUT";
      3:       return "DELETE";
      4:       return "PATCH";
      5:       return "HEAD";
      default: return "OPTIONS";
    endcase
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] any_letter();
    return mix_case(8'("A") + 8'($urandom_range(25)));
  endfunction

  function automatic logic [7:0] key_char();
    return ($urandom_range(7) == 0) ? 8'("-") : any_letter();
  endfunction

  // Line content: never CR or LF
  function automatic logic [7:0] text_char();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: return any_letter();
      9, 10:                     return CH_QMARK;
      11:                        return CH_COLON;
      12, 13:                    return CH_SPACE;
      14:                        return 8'("/");
      15:                        return 8'("=");
      16:                        return 8'($urandom_range(255, 128));
      default:                   return 8'($urandom_range(126, 33));
    endcase
  endfunction

  // Noise: line breaks and separators weighted up
  function automatic logic [7:0] wild_char();
    case ($urandom_range(9))
      0, 1:    return CH_CR;
      2:       return CH_LF;
      3:       return CH_SPACE;
      4:       return CH_COLON;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic begin_request();
    fresh = 1'b1;
    request_count++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    byte_stream.push_back('{data_byte: b, start_of_request: fresh});
    fresh = 1'b0;
  endtask

  // '|' stands for CR LF, '~' for a lone CR
  task automatic add_text(input string s);
    for (int j = 0; j < s.len(); j++) begin
      if (s[j] == "|") begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end else if (s[j] == "~") begin
        add_byte(CH_CR);
      end else begin
        add_byte(s[j]);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    string verb;
    int    k;

    // directed requests
    begin_request(); add_text("get /a?b=1 HTTP/1.1|HOST:  ex|Key:|plain line|A:  ||zz");
    begin_request(); add_text("|X-Up: v||");
    begin_request(); add_text("POST /p H||");
    begin_request(); add_text("pUt /?q H||");
    begin_request(); add_text("DELETE  H||");
    begin_request(); add_text("PATCH /x? H||");
    begin_request(); add_text("head /h H||");
    begin_request(); add_text("OPTIONS * H||");
    begin_request(); add_text("GETS /u H||");
    begin_request(); add_text("GE / H||");
    begin_request(); add_text("XY /z H||");
    begin_request(); add_text("GET /a~b?c H|V: a~b|:v||");
    begin_request(); add_text("GET /??x H||");
    begin_request(); add_text("BROKEN|A: b||");
    begin_request(); add_text("GET /x H~~||");
    begin_request(); add_text("GET /");
    add_byte(8'hff); add_byte(8'h00);
    add_text(" H|Z:"); add_byte(8'hff); add_text("||");
    begin_request(); add_text("GET /abc");
    begin_request(); add_text("PUT / H||");

    // random traffic: mostly well-formed requests, some noise
    while (byte_stream.size() < 850) begin
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) == 1) begin_request();
        repeat ($urandom_range(30, 1)) add_byte(wild_char());
      end else begin
        begin_request();
        if ($urandom_range(11) == 0) begin
          add_text("|");
        end else begin
          k = $urandom_range(9);
          if (k < 7 || k == 9) begin
            verb = method_word(k % 7);
            for (int j = 0; j < verb.len(); j++) add_byte(mix_case(verb[j]));
            if (k == 9) add_byte(any_letter());
          end else if (k == 7) begin
            repeat ($urandom_range(8, 1)) add_byte(any_letter());
          end
          add_byte(CH_SPACE);
          repeat ($urandom_range(8)) add_byte(text_char());
          if ($urandom_range(9) != 0) add_byte(CH_SPACE);
          add_text("HTTP/1.1|");
        end
        repeat ($urandom_range(4)) begin
          if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(6)) add_byte(key_char());
          end else begin
            repeat ($urandom_range(6)) add_byte(key_char());
            add_byte(CH_COLON);
            repeat ($urandom_range(3)) add_byte(CH_SPACE);
            repeat ($urandom_range(8)) add_byte(text_char());
            if ($urandom_range(7) == 0) begin
              add_byte(CH_CR);
              add_byte(any_letter());
            end
          end
          add_text("|");
        end
        if ($urandom_range(9) != 0) add_text("|");
        repeat ($urandom_range(3)) add_byte(text_char());
      end
    end

    // close with one clean request
    begin_request(); add_text("DELETE /after HTTP/1.1|Host: a||");

    // hold reset, then offer every request byte
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < byte_stream.size(); i++) begin
      while (!calm && $urandom_range(99) < 11) begin
        request_valid <= 1'b0;
        @(posedge clk);
      end
      request <= byte_stream[i];
      request_valid <= 1'b1;
      do @(posedge clk); while (!request_ready);
    end
    request_valid <= 1'b0;

    // drain the remaining results
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d requests: directed cases and random traffic.",
             byte_stream.size(), request_count);
    $display("Compared %0d results, %0d mismatches, %0d left outstanding.",
             compared, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("http_request_header_tokenizer_tb OK");
    end else begin
      $display("http_request_header_tokenizer_tb NOT OK");
    end
    $finish;
  end

  // Result side: random stalls plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (cycle_no == 700) begin
        hold = 400;
      end
      result_ready <= (hold == 0) && (calm || $urandom_range(99) >= 11);
    end
  end

  // Run limit
  initial begin
    #200_000;
    $display("Timeout with %0d results outstanding.", outstanding);
    $display("http_request_header_tokenizer_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
design/htt_pkg.sv
design/htt_core.sv
design/http_request_header_tokenizer.sv
bench/http_request_header_tokenizer_checker.sv
bench/http_request_header_tokenizer_tb.sv
